FILE: hdl/msdec_pkg.sv
// Shared types, codes and constants for the track-2 stripe decoder.
// Used by the front end, back end, top level and bench; depends on nothing else.
package msdec_pkg;

    // Track-2 framing: four data bits plus one odd-parity bit per character
    localparam int WORD_BITS = 5;
    localparam int DATA_BITS = WORD_BITS - 1;

    // Defaults for the top-level parameters
    localparam int MAX_WORDS_DEF  = 40;
    localparam int MAX_DIGITS_DEF = 19;

    // Depths of the command queue and of the result queue
    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 2;

    // Configuration port
    localparam int CFG_IW = 2;
    localparam int CFG_DW = WORD_BITS;
    localparam logic [CFG_IW-1:0] CFG_START_SENTINEL = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_END_SENTINEL   = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_SEPARATOR      = 2'd2;

    // Register reset values
    localparam logic [WORD_BITS-1:0] START_SENTINEL_RST = 5'd11;
    localparam logic [DATA_BITS-1:0] END_SENTINEL_RST   = 4'd15;
    localparam logic [DATA_BITS-1:0] SEPARATOR_RST      = 4'd13;

    // Input opcodes
    localparam logic OP_STROBE = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Command kinds handed from front to back
    localparam logic KIND_BIT     = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // Read status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // Card number width
    localparam int NUM_W = 64;

    typedef struct packed {
        logic opcode;
        logic data_level;
        logic enable_level;
    } request_t;

    typedef struct packed {
        logic             read_status;
        logic [NUM_W-1:0] acct_number;
    } result_t;

    typedef struct packed {
        logic kind;
        logic data_bit;
    } cmd_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] start_sentinel;
        logic [DATA_BITS-1:0] end_sentinel;
        logic [DATA_BITS-1:0] separator;
    } cfg_t;

endpackage

FILE: hdl/msdec_fifo.sv
// Small flop-based queue with first-word fall-through read.
// Depends on no package; used for the command and result queues.
module msdec_fifo #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [WIDTH-1:0]             wr_data,
    input  logic                         rd_en,
    output logic [WIDTH-1:0]             rd_data,
    output logic                         empty,
    output logic                         full,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [IW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [IW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg,  count_next;
    logic             do_wr, do_rd;

    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;

    // Pointer and fill-count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == IW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == IW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = entry_reg[rd_ptr_reg];
    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CW'(DEPTH));
    assign count   = count_reg;

endmodule

FILE: hdl/msdec_front.sv
// Front end: tracks the enable pin and turns input transfers into commands.
// Depends on msdec_pkg.
module msdec_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  msdec_pkg::request_t request,
    output logic               cmd_valid,
    output msdec_pkg::cmd_t    cmd
);

    logic enable_prev_reg, enable_prev_next;
    logic is_strobe, is_sample;

    assign is_strobe = (request.opcode == msdec_pkg::OP_STROBE);
    assign is_sample = (request.opcode == msdec_pkg::OP_SAMPLE);

    // Strobes count only while enable is asserted (low); a release is a rising sample
    always_comb
    begin
        cmd_valid = 1'b0;
        if (take && !enable_prev_reg)
        begin
            cmd_valid = is_strobe || (is_sample && request.enable_level);
        end
        cmd.kind     = is_strobe ? msdec_pkg::KIND_BIT : msdec_pkg::KIND_RELEASE;
        cmd.data_bit = ~request.data_level;
    end

    // Enable history
    always_comb
    begin
        enable_prev_next = enable_prev_reg;
        if (take && is_sample)
        begin
            enable_prev_next = request.enable_level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_prev_reg <= 1'b1;
        end
        else
        begin
            enable_prev_reg <= enable_prev_next;
        end
    end

endmodule

FILE: hdl/msdec_back.sv
// Back end: configuration registers, sentinel hunt, word framing, LRC and number.
// Depends on msdec_pkg.
module msdec_back #(
    parameter int MAX_WORDS  = msdec_pkg::MAX_WORDS_DEF,
    parameter int MAX_DIGITS = msdec_pkg::MAX_DIGITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [msdec_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [msdec_pkg::CFG_DW-1:0]   cfg_data,
    input  logic                           go,
    input  msdec_pkg::cmd_t                cmd,
    output logic                           res_valid,
    output msdec_pkg::result_t             res
);

    localparam int WB  = msdec_pkg::WORD_BITS;
    localparam int DB  = msdec_pkg::DATA_BITS;
    localparam int NW  = msdec_pkg::NUM_W;
    localparam int WCW = $clog2(MAX_WORDS + 1);
    localparam int DGW = $clog2(MAX_DIGITS + 1);

    msdec_pkg::cfg_t cfg_reg, cfg_next;

    logic           capturing_reg, capturing_next;
    logic [WB-1:0]  hunt_reg,      hunt_next;
    logic [2:0]     bitpos_reg,    bitpos_next;
    logic [DB-1:0]  word_reg,      word_next;
    logic           parity_reg,    parity_next;
    logic [WCW-1:0] wcount_reg,    wcount_next;
    logic [DB-1:0]  lrc_reg,       lrc_next;
    logic           end_found_reg, end_found_next;
    logic           done_reg,      done_next;
    logic           error_reg,     error_next;
    logic [NW-1:0]  number_reg,    number_next;
    logic [DGW-1:0] digits_reg,    digits_next;

    logic [WB-1:0]  hunt_shift;
    logic           parity_new;
    logic           halted;
    logic [NW-1:0]  number_x10;

    // Configuration writes; indexes beyond the list are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                msdec_pkg::CFG_START_SENTINEL: cfg_next.start_sentinel = cfg_data;
                msdec_pkg::CFG_END_SENTINEL:   cfg_next.end_sentinel   = cfg_data[DB-1:0];
                msdec_pkg::CFG_SEPARATOR:      cfg_next.separator      = cfg_data[DB-1:0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    // Helpers for the bit path
    assign hunt_shift = {cmd.data_bit, hunt_reg[WB-1:1]};
    assign parity_new = parity_reg ^ cmd.data_bit;
    assign halted     = done_reg || error_reg || (wcount_reg >= WCW'(MAX_WORDS));
    assign number_x10 = {number_reg[NW-4:0], 3'b000} + {number_reg[NW-2:0], 1'b0}
                        + NW'(word_reg);

    // Result of a release
    assign res_valid       = go && (cmd.kind == msdec_pkg::KIND_RELEASE);
    assign res.read_status = (capturing_reg && done_reg && !error_reg && (lrc_reg == '0))
                             ? msdec_pkg::STATUS_OK : msdec_pkg::STATUS_ERR;
    assign res.acct_number = number_reg;

    // Swipe state update, one command per cycle while go is high
    always_comb
    begin
        capturing_next = capturing_reg;
        hunt_next      = hunt_reg;
        bitpos_next    = bitpos_reg;
        word_next      = word_reg;
        parity_next    = parity_reg;
        wcount_next    = wcount_reg;
        lrc_next       = lrc_reg;
        end_found_next = end_found_reg;
        done_next      = done_reg;
        error_next     = error_reg;
        number_next    = number_reg;
        digits_next    = digits_reg;

        if (go && (cmd.kind == msdec_pkg::KIND_RELEASE))
        begin
            // release: clear everything for the next swipe
            capturing_next = 1'b0;
            hunt_next      = '0;
            bitpos_next    = '0;
            word_next      = '0;
            parity_next    = 1'b0;
            wcount_next    = '0;
            lrc_next       = '0;
            end_found_next = 1'b0;
            done_next      = 1'b0;
            error_next     = 1'b0;
            number_next    = '0;
            digits_next    = '0;
        end
        else if (go && !capturing_reg)
        begin
            // hunting the start sentinel
            hunt_next = hunt_shift;
            if (hunt_shift == cfg_reg.start_sentinel)
            begin
                capturing_next = 1'b1;
                hunt_next      = '0;
                bitpos_next    = '0;
                word_next      = '0;
                parity_next    = 1'b0;
                wcount_next    = '0;
                lrc_next       = cfg_reg.start_sentinel[DB-1:0];
                end_found_next = 1'b0;
                done_next      = 1'b0;
                error_next     = 1'b0;
                number_next    = '0;
                digits_next    = '0;
            end
        end
        else if (go && !halted)
        begin
            if (bitpos_reg < 3'(WB - 1))
            begin
                // data bit, LSB first
                parity_next = parity_new;
                word_next   = {cmd.data_bit, word_reg[DB-1:1]};
                bitpos_next = bitpos_reg + 3'd1;
            end
            else
            begin
                // parity bit closes the word
                bitpos_next = '0;
                word_next   = '0;
                parity_next = 1'b0;
                if (!parity_new)
                begin
                    error_next = 1'b1;
                end
                else
                begin
                    lrc_next    = lrc_reg ^ word_reg;
                    wcount_next = wcount_reg + 1'b1;
                    if (digits_reg < DGW'(MAX_DIGITS))
                    begin
                        if (word_reg == cfg_reg.separator)
                        begin
                            digits_next = DGW'(MAX_DIGITS);
                        end
                        else
                        begin
                            number_next = number_x10;
                            digits_next = digits_reg + 1'b1;
                        end
                    end
                    if (end_found_reg)
                    begin
                        done_next = 1'b1;
                    end
                    else if (word_reg == cfg_reg.end_sentinel)
                    begin
                        end_found_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_sentinel <= msdec_pkg::START_SENTINEL_RST;
            cfg_reg.end_sentinel   <= msdec_pkg::END_SENTINEL_RST;
            cfg_reg.separator      <= msdec_pkg::SEPARATOR_RST;
            capturing_reg          <= 1'b0;
            hunt_reg               <= '0;
            bitpos_reg             <= '0;
            word_reg               <= '0;
            parity_reg             <= 1'b0;
            wcount_reg             <= '0;
            lrc_reg                <= '0;
            end_found_reg          <= 1'b0;
            done_reg               <= 1'b0;
            error_reg              <= 1'b0;
            number_reg             <= '0;
            digits_reg             <= '0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            capturing_reg <= capturing_next;
            hunt_reg      <= hunt_next;
            bitpos_reg    <= bitpos_next;
            word_reg      <= word_next;
            parity_reg    <= parity_next;
            wcount_reg    <= wcount_next;
            lrc_reg       <= lrc_next;
            end_found_reg <= end_found_next;
            done_reg      <= done_next;
            error_reg     <= error_next;
            number_reg    <= number_next;
            digits_reg    <= digits_next;
        end
    end

endmodule

FILE: hdl/magstripe_track2_decoder_unit.sv
// Track-2 magnetic stripe decoder: takes one input transfer per clock while the command
// queue is not full. The front end decodes each transfer in the cycle it is taken; strobes
// while enable is released and samples without a release edge end there and never reach
// the back end. Other items pass through a two-entry command queue to the back end, which
// retires one command per cycle (the times-ten add on the 64-bit card number is its longest
// path) and writes a result into a two-entry result queue. With both queues empty, a
// releasing sample is registered in the command queue and its result in the result queue
// ahead of the result ports; the back end stalls only while the result queue is full.
// Depends on msdec_pkg, msdec_fifo, msdec_front and msdec_back.
module magstripe_track2_decoder_unit #(
    parameter int MAX_WORDS  = msdec_pkg::MAX_WORDS_DEF,
    parameter int MAX_DIGITS = msdec_pkg::MAX_DIGITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // input queue side
    input  logic                         push,
    output logic                         full,
    input  msdec_pkg::request_t          request,
    // result queue side
    output logic                         empty,
    input  logic                         pop,
    output msdec_pkg::result_t           result,
    // configuration writes
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [msdec_pkg::CFG_IW-1:0] cfg_index,
    input  logic [msdec_pkg::CFG_DW-1:0] cfg_data
);

    localparam int CMD_W  = $bits(msdec_pkg::cmd_t);
    localparam int RES_W  = $bits(msdec_pkg::result_t);
    localparam int CCW    = $clog2(msdec_pkg::CMD_DEPTH + 1);
    localparam int RCW    = $clog2(msdec_pkg::RES_DEPTH + 1);

    logic               take;
    logic               cmd_valid;
    msdec_pkg::cmd_t    cmd_in;
    msdec_pkg::cmd_t    cmd_head;
    logic               cmd_empty;
    logic [CCW-1:0]     cmd_count;
    logic               go;
    logic               res_valid;
    msdec_pkg::result_t res_in;
    logic               res_full;
    logic [RCW-1:0]     res_count;

    assign take      = push && !full;
    assign cfg_ready = 1'b1;

    // Front end
    msdec_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .request   (request),
        .cmd_valid (cmd_valid),
        .cmd       (cmd_in)
    );

    // Command queue between front and back
    msdec_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (msdec_pkg::CMD_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_valid),
        .wr_data (cmd_in),
        .rd_en   (go),
        .rd_data (cmd_head),
        .empty   (cmd_empty),
        .full    (full),
        .count   (cmd_count)
    );

    // Back end runs whenever a command waits and a result slot is free
    assign go = !cmd_empty && !res_full;

    msdec_back #(
        .MAX_WORDS  (MAX_WORDS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .go        (go),
        .cmd       (cmd_head),
        .res_valid (res_valid),
        .res       (res_in)
    );

    // Result queue
    msdec_fifo #(
        .WIDTH (RES_W),
        .DEPTH (msdec_pkg::RES_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res_in),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty),
        .full    (res_full),
        .count   (res_count)
    );

    // Back end drains the command queue when nothing new arrives
    a_cmd_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (go && !cmd_valid) |=> (cmd_count == $past(cmd_count) - CCW'(1)))
        else $error("command queue did not drain");

    // Only a release command produces a result
    a_res_from_release: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (go && cmd_head.kind == msdec_pkg::KIND_RELEASE))
        else $error("result without release command");

    // A produced result is visible the next cycle and the fill count moves accordingly
    a_res_visible: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !(pop && !empty)) |=> (!empty && res_count == $past(res_count) + RCW'(1)))
        else $error("result lost in result queue");

endmodule

FILE: dv/magstripe_track2_decoder_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for magstripe_track2_decoder_unit: random track-2 swipes, noise and
// register settings, checked against an in-bench decoder. Depends on msdec_pkg and the RTL.
module magstripe_track2_decoder_unit_test;

    localparam int LONG_HOLD = 300;

    typedef enum int {
        FLAW_NONE,
        FLAW_PARITY,
        FLAW_LRC,
        FLAW_NO_START,
        FLAW_NO_END,
        FLAW_NO_LRC
    } swipe_flaw_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          push = 1'b0;
    logic                          full;
    msdec_pkg::request_t           request = '0;
    logic                          empty;
    logic                          pop = 1'b0;
    msdec_pkg::result_t            result;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [msdec_pkg::CFG_IW-1:0]  cfg_index = '0;
    logic [msdec_pkg::CFG_DW-1:0]  cfg_data = '0;

    magstripe_track2_decoder_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .request   (request),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #1000000;
        $display("FAIL");
        $finish;
    end

    // Stimulus and expected swipe reports
    msdec_pkg::request_t request_q[$];
    msdec_pkg::result_t  swipe_reports_q[$];
    int          errors = 0;
    int          items_queued = 0;
    int          swipes_queued = 0;
    logic        long_hold = 1'b0;

    // Decoder shadow: register copies and swipe state
    logic [4:0]  cfg_start_sent;
    logic [3:0]  cfg_end_sent;
    logic [3:0]  cfg_separator;
    logic        ena_prev;
    logic        in_track;
    logic [4:0]  hunter;
    logic [2:0]  bit_idx;
    logic [3:0]  char_bits;
    logic        char_par;
    logic [5:0]  char_cnt;
    logic [3:0]  lrc_fold;
    logic        end_seen;
    logic        track_done;
    logic        track_err;
    logic [63:0] pan_acc;
    logic [4:0]  pan_digits;

    task automatic restart_swipe();
        in_track   = 1'b0;
        hunter     = '0;
        bit_idx    = '0;
        char_bits  = '0;
        char_par   = 1'b0;
        char_cnt   = '0;
        lrc_fold   = '0;
        end_seen   = 1'b0;
        track_done = 1'b0;
        track_err  = 1'b0;
        pan_acc    = '0;
        pan_digits = '0;
    endtask

    // One complete character: parity, LRC, card number digits, end of track
    task automatic close_char();
        if (!char_par)
            track_err = 1'b1;
        else
        begin
            lrc_fold = lrc_fold ^ char_bits;
            char_cnt = char_cnt + 6'd1;
            if (pan_digits < msdec_pkg::MAX_DIGITS_DEF)
            begin
                if (char_bits == cfg_separator)
                    pan_digits = 5'(msdec_pkg::MAX_DIGITS_DEF);
                else
                begin
                    pan_acc = pan_acc * 64'd10 + {60'd0, char_bits};
                    pan_digits = pan_digits + 5'd1;
                end
            end
            if (end_seen)
                track_done = 1'b1;
            else if (char_bits == cfg_end_sent)
                end_seen = 1'b1;
        end
    endtask

    task automatic shift_bit(logic b);
        if (!in_track)
        begin
            hunter = {b, hunter[4:1]};
            if (hunter == cfg_start_sent)
            begin
                restart_swipe();
                in_track = 1'b1;
                lrc_fold = cfg_start_sent[3:0];
            end
        end
        else if (!(track_done || track_err || char_cnt >= msdec_pkg::MAX_WORDS_DEF))
        begin
            char_par = char_par ^ b;
            if (bit_idx < msdec_pkg::DATA_BITS)
            begin
                char_bits = {b, char_bits[3:1]};
                bit_idx = bit_idx + 3'd1;
            end
            else
            begin
                close_char();
                bit_idx = '0;
                char_bits = '0;
                char_par = 1'b0;
            end
        end
    endtask

    // Predict the report (if any) caused by one accepted request
    task automatic track2_predict(msdec_pkg::request_t r);
        msdec_pkg::result_t rep;
        if (r.opcode == msdec_pkg::OP_STROBE)
        begin
            if (!ena_prev)
                shift_bit(~r.data_level);
        end
        else
        begin
            if (r.enable_level && !ena_prev)
            begin
                rep.read_status = (in_track && track_done && !track_err && lrc_fold == 4'd0)
                                  ? msdec_pkg::STATUS_OK : msdec_pkg::STATUS_ERR;
                rep.acct_number = pan_acc;
                swipe_reports_q.push_back(rep);
                restart_swipe();
            end
            ena_prev = r.enable_level;
        end
    endtask

    function automatic int unsigned draw_idle(bit calm);
        return calm ? 0 : $urandom_range(0, 7);
    endfunction

    // Request driver
    int unsigned send_wait = 0;
    bit          send_calm = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            request <= '0;
            send_wait <= 0;
        end
        else
        begin
            if (push && !full)
                track2_predict(request);
            if (push && full)
                ;   // hold the offered item
            else if (send_wait != 0)
            begin
                push <= 1'b0;
                send_wait <= send_wait - 1;
            end
            else if (request_q.size() != 0)
            begin
                request <= request_q.pop_front();
                push <= 1'b1;
                if ($urandom_range(0, 31) == 0)
                    send_calm = ~send_calm;
                send_wait <= draw_idle(send_calm);
            end
            else
                push <= 1'b0;
        end
    end

    // Result monitor and pop control
    int unsigned pop_wait = 0;
    int unsigned hold_cnt = 0;
    int unsigned pop_idle;
    bit          recv_calm = 1'b0;
    logic        hold_begun = 1'b0;

    task automatic check_report(msdec_pkg::result_t got);
        msdec_pkg::result_t want;
        if (swipe_reports_q.size() == 0)
        begin
            $display("%0t: unexpected result: status %0b number %0d",
                     $time, got.read_status, got.acct_number);
            errors++;
        end
        else
        begin
            want = swipe_reports_q.pop_front();
            if (got.read_status !== want.read_status)
            begin
                $display("%0t: read_status expected %0b got %0b",
                         $time, want.read_status, got.read_status);
                errors++;
            end
            if (got.acct_number !== want.acct_number)
            begin
                $display("%0t: acct_number expected %0d got %0d",
                         $time, want.acct_number, got.acct_number);
                errors++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            pop_wait <= 0;
            hold_cnt <= 0;
            hold_begun <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
                check_report(result);
            if (long_hold && !hold_begun)
            begin
                hold_begun <= 1'b1;
                hold_cnt <= LONG_HOLD;
                pop <= 1'b0;
            end
            else if (hold_cnt != 0)
            begin
                hold_cnt <= hold_cnt - 1;
                pop <= 1'b0;
            end
            else if (pop && !empty)
            begin
                if ($urandom_range(0, 31) == 0)
                    recv_calm = ~recv_calm;
                pop_idle = draw_idle(recv_calm);
                pop <= (pop_idle == 0);
                pop_wait <= (pop_idle == 0) ? 0 : pop_idle - 1;
            end
            else
            begin
                pop <= (pop_wait == 0);
                if (pop_wait != 0)
                    pop_wait <= pop_wait - 1;
            end
        end
    end

    // Stimulus helpers
    task automatic queue_item(logic op, logic lvl, logic ena);
        msdec_pkg::request_t r;
        r.opcode = op;
        r.data_level = lvl;
        r.enable_level = ena;
        request_q.push_back(r);
        items_queued++;
    endtask

    // Strobe carrying bit b (the pin is the inverse); enable pin is don't-care
    task automatic queue_strobe(logic b);
        queue_item(msdec_pkg::OP_STROBE, ~b, 1'($urandom_range(0, 1)));
    endtask

    task automatic queue_sample(logic ena);
        queue_item(msdec_pkg::OP_SAMPLE, 1'($urandom_range(0, 1)), ena);
    endtask

    // Four data bits LSB first, then the odd-parity bit (inverted when bad)
    task automatic queue_char(logic [3:0] c, logic good);
        int k;
        for (k = 0; k < msdec_pkg::DATA_BITS; k++)
            queue_strobe(c[k]);
        queue_strobe(good ? ~^c : ^c);
    endtask

    // Whole swipe: enable, clock zeros, start sentinel, chars, end sentinel, LRC, zeros, release
    task automatic queue_swipe(input logic [3:0] chars[$], input swipe_flaw_t flaw);
        logic [4:0] hunt_copy;
        logic [3:0] fold;
        int         k;
        int         bad;
        hunt_copy = '0;
        fold = cfg_start_sent[3:0];
        bad = $urandom_range(0, chars.size());
        queue_sample(1'b0);
        // with an all-zero sentinel any leading zero would already lock
        if (cfg_start_sent != 5'd0)
            repeat ($urandom_range(0, 8)) queue_strobe(1'b0);
        if (flaw != FLAW_NO_START)
            for (k = 0; k < msdec_pkg::WORD_BITS; k++)
            begin
                queue_strobe(cfg_start_sent[k]);
                hunt_copy = {cfg_start_sent[k], hunt_copy[4:1]};
                if (hunt_copy == cfg_start_sent)
                    break;
            end
        for (k = 0; k < chars.size(); k++)
        begin
            queue_char(chars[k], !(flaw == FLAW_PARITY && k == bad));
            fold = fold ^ chars[k];
        end
        if (flaw != FLAW_NO_END)
        begin
            queue_char(cfg_end_sent, !(flaw == FLAW_PARITY && bad == chars.size()));
            fold = fold ^ cfg_end_sent;
        end
        if (flaw == FLAW_LRC)
            fold = fold ^ 4'($urandom_range(1, 15));
        if (flaw != FLAW_NO_LRC)
            queue_char(fold, 1'b1);
        repeat ($urandom_range(0, 6)) queue_strobe(1'b0);
        queue_sample(1'b1);
        swipes_queued++;
    endtask

    // Random mix of everything, always left with enable released
    task automatic queue_noise();
        repeat ($urandom_range(4, 24))
            queue_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
        queue_sample(1'b1);
    endtask

    task automatic queue_random_swipe();
        logic [3:0]  chars[$];
        logic [3:0]  c;
        int          n;
        int          sep;
        int          k;
        swipe_flaw_t flaw;
        // mostly short card numbers; now and then long enough to hit the word cap
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 44) : $urandom_range(0, 10);
        sep = $urandom_range(0, 1) ? $urandom_range(0, n) : -1;
        for (k = 0; k < n; k++)
        begin
            if (k == sep)
                c = cfg_separator;
            else
            begin
                c = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(10, 15))
                                                 : 4'($urandom_range(0, 9));
                if (c == cfg_end_sent)
                    c = c + 4'd1;
            end
            chars.push_back(c);
        end
        case ($urandom_range(0, 11))
            6:       flaw = FLAW_PARITY;
            7:       flaw = FLAW_LRC;
            8:       flaw = FLAW_NO_START;
            9:       flaw = FLAW_NO_END;
            10:      flaw = FLAW_NO_LRC;
            default: flaw = FLAW_NONE;
        endcase
        queue_swipe(chars, flaw);
    endtask

    // Register write over the config channel; shadow updated on the transfer
    task automatic write_reg(logic [msdec_pkg::CFG_IW-1:0] idx,
                             logic [msdec_pkg::CFG_DW-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            msdec_pkg::CFG_START_SENTINEL: cfg_start_sent = val;
            msdec_pkg::CFG_END_SENTINEL:   cfg_end_sent = val[3:0];
            msdec_pkg::CFG_SEPARATOR:      cfg_separator = val[3:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic write_all(logic [4:0] ss, logic [3:0] es, logic [3:0] fs);
        write_reg(msdec_pkg::CFG_START_SENTINEL, ss);
        write_reg(msdec_pkg::CFG_END_SENTINEL, {1'($urandom_range(0, 1)), es});
        write_reg(msdec_pkg::CFG_SEPARATOR, {1'($urandom_range(0, 1)), fs});
    endtask

    // Wait until every item is taken and every report has come back
    task automatic drain();
        do
            @(negedge clk);
        while (request_q.size() != 0 || push || swipe_reports_q.size() != 0);
        repeat (10) @(negedge clk);
    endtask

    // Main sequence
    initial
    begin
        logic [3:0] chars[$];
        int         s;
        int         chunk_start;
        int         swipe_start;

        cfg_start_sent = msdec_pkg::START_SENTINEL_RST;
        cfg_end_sent = msdec_pkg::END_SENTINEL_RST;
        cfg_separator = msdec_pkg::SEPARATOR_RST;
        ena_prev = 1'b1;
        restart_swipe();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: strobes while released, samples with no edge, release with no sentinel
        queue_strobe(1'b0);
        queue_strobe(1'b1);
        queue_sample(1'b1);
        queue_sample(1'b0);
        queue_sample(1'b0);
        queue_strobe(1'b1);
        queue_sample(1'b1);
        // clean swipe with a digit above nine and the field separator
        chars = '{4'd9, 4'd12, cfg_separator, 4'd5};
        queue_swipe(chars, FLAW_NONE);
        drain();

        // Random phases over several register settings, extremes first
        for (s = 0; s < 5; s++)
        begin
            case (s)
                0: write_all(5'd31, 4'd0, 4'd15);
                1: write_all(5'd0, 4'd15, 4'd0);
                4: write_all(msdec_pkg::START_SENTINEL_RST, msdec_pkg::END_SENTINEL_RST,
                             msdec_pkg::SEPARATOR_RST);
                default: write_all(5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
                                   4'($urandom_range(0, 15)));
            endcase
            // back-pressure: result side stops popping while tiny swipes keep coming
            if (s == 2)
            begin
                long_hold = 1'b1;
                repeat (24)
                begin
                    queue_sample(1'b0);
                    queue_strobe(1'($urandom_range(0, 1)));
                    queue_strobe(1'($urandom_range(0, 1)));
                    queue_sample(1'b1);
                end
            end
            chunk_start = items_queued;
            swipe_start = swipes_queued;
            while (items_queued - chunk_start < 150 || swipes_queued - swipe_start < 2)
            begin
                if ($urandom_range(0, 3) == 0)
                    queue_noise();
                else
                    queue_random_swipe();
            end
            drain();
        end

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
hdl/msdec_pkg.sv
hdl/msdec_fifo.sv
hdl/msdec_front.sv
hdl/msdec_back.sv
hdl/magstripe_track2_decoder_unit.sv
dv/magstripe_track2_decoder_unit_test.sv
